### hw/rtl/elr_pkg.sv
package elr_pkg;

  // field widths of the item and pixel channels
  localparam int COORD_BITS  = 16;
  localparam int RADIUS_BITS = 13;
  localparam int PIX_BITS    = COORD_BITS + 1;

  // a radius that passes the start check is positive, so its sign bit is dropped
  localparam int RMAG_BITS   = RADIUS_BITS - 1;
  localparam int SQ_BITS     = 2 * RMAG_BITS;
  // walk coordinates: x counts up from zero, y counts down to minus one
  localparam int STEP_BITS   = RADIUS_BITS + 1;
  // multiplier factor: 2x+1 or 1-2y
  localparam int FACT_BITS   = STEP_BITS + 2;
  localparam int PROD_BITS   = FACT_BITS + SQ_BITS + 1;
  localparam int ERR_BITS    = 3 * RMAG_BITS + 4;

  // command queue between front and back
  localparam int QDEPTH      = 2;
  localparam int QPTR_BITS   = $clog2(QDEPTH);
  localparam int QCNT_BITS   = QPTR_BITS + 1;

  // item opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // classified command as held in the queue
  typedef struct packed {
    logic                         is_start;
    logic signed [COORD_BITS-1:0] ctr_x;
    logic signed [COORD_BITS-1:0] ctr_y;
    logic [RMAG_BITS-1:0]         rad_a;
    logic [RMAG_BITS-1:0]         rad_b;
    logic [SQ_BITS-1:0]           a_sq;
    logic [SQ_BITS-1:0]           b_sq;
    logic [31:0]                  color;
  } cmd_t;

  // back end status seen by the top level
  typedef struct packed {
    logic       busy;
    logic       updating;
    logic       emitting;
    logic [1:0] emit_cnt;
  } back_status_t;

endpackage

### hw/rtl/elr_in_if.sv
interface elr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  opcode;
  logic signed [elr_pkg::COORD_BITS-1:0]  center_x;
  logic signed [elr_pkg::COORD_BITS-1:0]  center_y;
  logic signed [elr_pkg::RADIUS_BITS-1:0] radius_x;
  logic signed [elr_pkg::RADIUS_BITS-1:0] radius_y;
  logic [31:0]                           color;

  modport source (
    output valid, opcode, center_x, center_y, radius_x, radius_y, color,
    input  ready
  );
  modport sink (
    input  valid, opcode, center_x, center_y, radius_x, radius_y, color,
    output ready
  );
endinterface

### hw/rtl/elr_out_if.sv
interface elr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [elr_pkg::PIX_BITS-1:0] pixel_x;
  logic signed [elr_pkg::PIX_BITS-1:0] pixel_y;
  logic [31:0]                         pixel_color;
  logic                                last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last,
    output ready
  );
endinterface

### hw/rtl/elr_front.sv
module elr_front (
  elr_in_if.sink         cmd,
  output logic           push_valid,
  input  logic           push_ready,
  output elr_pkg::cmd_t  push_data
);

  logic                            radii_ok;
  logic [elr_pkg::RMAG_BITS-1:0]   rad_a;
  logic [elr_pkg::RMAG_BITS-1:0]   rad_b;

  // a start needs both radii strictly positive
  assign radii_ok = !cmd.radius_x[elr_pkg::RADIUS_BITS-1] && (cmd.radius_x != '0) &&
                    !cmd.radius_y[elr_pkg::RADIUS_BITS-1] && (cmd.radius_y != '0);

  assign rad_a = cmd.radius_x[elr_pkg::RMAG_BITS-1:0];
  assign rad_b = cmd.radius_y[elr_pkg::RMAG_BITS-1:0];

  // items are always taken while the queue has room; rejected starts are dropped
  assign cmd.ready  = push_ready;
  assign push_valid = cmd.valid && ((cmd.opcode == elr_pkg::OP_TICK) || radii_ok);

  // squares are formed here and registered by the queue
  always_comb begin
    push_data.is_start = (cmd.opcode == elr_pkg::OP_START);
    push_data.ctr_x    = cmd.center_x;
    push_data.ctr_y    = cmd.center_y;
    push_data.rad_a    = rad_a;
    push_data.rad_b    = rad_b;
    push_data.a_sq     = elr_pkg::SQ_BITS'(rad_a) * elr_pkg::SQ_BITS'(rad_a);
    push_data.b_sq     = elr_pkg::SQ_BITS'(rad_b) * elr_pkg::SQ_BITS'(rad_b);
    push_data.color    = cmd.color;
  end

endmodule

### hw/rtl/elr_cmd_queue.sv
module elr_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  elr_pkg::cmd_t  push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output elr_pkg::cmd_t  pop_data
);

  elr_pkg::cmd_t                   entries [elr_pkg::QDEPTH];
  logic [elr_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [elr_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [elr_pkg::QCNT_BITS-1:0]   count;
  logic                            push;
  logic                            pop;

  assign push_ready = (count != elr_pkg::QCNT_BITS'(elr_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/elr_back.sv
module elr_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  elr_pkg::cmd_t         pop_data,
  elr_out_if.source             pixels,
  output elr_pkg::back_status_t status
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic                                 state;
  logic                                 busy;
  logic [elr_pkg::STEP_BITS-1:0]        cur_x;
  logic signed [elr_pkg::STEP_BITS-1:0] cur_y;
  logic signed [elr_pkg::ERR_BITS-1:0]  err_term;
  logic signed [elr_pkg::ERR_BITS-1:0]  prod;
  logic                                 init;
  logic signed [elr_pkg::COORD_BITS-1:0] ctr_x;
  logic signed [elr_pkg::COORD_BITS-1:0] ctr_y;
  logic [elr_pkg::SQ_BITS-1:0]          a_squared;
  logic [elr_pkg::SQ_BITS-1:0]          b_squared;
  logic [31:0]                          held_color;

  // pixel burst registers
  logic                                  e_act;
  logic [1:0]                            e_cnt;
  logic signed [elr_pkg::COORD_BITS-1:0] e_cx;
  logic signed [elr_pkg::COORD_BITS-1:0] e_cy;
  logic signed [elr_pkg::STEP_BITS:0]    e_dx;
  logic signed [elr_pkg::STEP_BITS-1:0]  e_dy;
  logic [31:0]                           e_color;
  logic                                  e_fin;

  logic                                  emit_free;
  logic                                  out_fire;
  logic                                  pop;
  logic                                  step;
  logic                                  neg;
  logic                                  fin_now;
  logic [elr_pkg::STEP_BITS:0]           dx_now;
  logic signed [elr_pkg::FACT_BITS-1:0]  fact;
  logic [elr_pkg::SQ_BITS-1:0]           msq;
  logic signed [elr_pkg::PROD_BITS-1:0]  prod_full;
  logic signed [elr_pkg::PIX_BITS-1:0]   px_base;
  logic signed [elr_pkg::PIX_BITS-1:0]   px_off;
  logic signed [elr_pkg::PIX_BITS-1:0]   py_base;
  logic signed [elr_pkg::PIX_BITS-1:0]   py_off;

  // handshakes: the next command waits for the error update and a free burst slot
  assign out_fire  = pixels.valid && pixels.ready;
  assign emit_free = !e_act || (pixels.ready && (e_cnt == 2'd3));
  assign pop_ready = (state == ST_IDLE) && emit_free;
  assign pop       = pop_valid && pop_ready;
  assign step      = pop && !pop_data.is_start && busy;

  // step classification from the current error sign
  assign neg     = err_term[elr_pkg::ERR_BITS-1];
  assign fin_now = !neg && (cur_y[elr_pkg::STEP_BITS-1] || (cur_y == '0));
  assign dx_now  = {1'b0, cur_x} - {{elr_pkg::STEP_BITS{1'b0}}, !neg};

  // shared multiplier: b*b*a on start, step increment on tick
  always_comb begin
    if (pop_data.is_start) begin
      fact = $signed(elr_pkg::FACT_BITS'(pop_data.rad_a));
      msq  = pop_data.b_sq;
    end else if (neg) begin
      fact = $signed({1'b0, cur_x, 1'b1});
      msq  = b_squared;
    end else begin
      fact = $signed(elr_pkg::FACT_BITS'(1) - {cur_y[elr_pkg::STEP_BITS-1], cur_y, 1'b0});
      msq  = a_squared;
    end
    prod_full = fact * $signed({1'b0, msq});
  end

  // walk state and error accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop && pop_data.is_start) begin
            busy  <= 1'b1;
            state <= ST_UPD;
          end else if (step) begin
            if (fin_now) begin
              busy <= 1'b0;
            end
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop && pop_data.is_start) begin
      ctr_x      <= pop_data.ctr_x;
      ctr_y      <= pop_data.ctr_y;
      a_squared  <= pop_data.a_sq;
      b_squared  <= pop_data.b_sq;
      held_color <= pop_data.color;
      cur_x      <= '0;
      cur_y      <= $signed(elr_pkg::STEP_BITS'(pop_data.rad_b));
      prod       <= prod_full[elr_pkg::ERR_BITS-1:0];
      init       <= 1'b1;
    end else if (step) begin
      if (neg) begin
        cur_x <= cur_x + 1'b1;
      end else begin
        cur_y <= cur_y - $signed(elr_pkg::STEP_BITS'(1));
      end
      prod <= prod_full[elr_pkg::ERR_BITS-1:0];
      init <= 1'b0;
    end
    if (state == ST_UPD) begin
      err_term <= init ? -prod : err_term + prod;
    end
  end

  // four mirrored pixels per step
  always_ff @(posedge clk) begin
    if (rst) begin
      e_act <= 1'b0;
      e_cnt <= '0;
    end else begin
      if (step) begin
        e_act <= 1'b1;
        e_cnt <= '0;
      end else if (out_fire) begin
        e_cnt <= e_cnt + 1'b1;
        if (e_cnt == 2'd3) begin
          e_act <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      e_cx    <= ctr_x;
      e_cy    <= ctr_y;
      e_dx    <= $signed(dx_now);
      e_dy    <= cur_y;
      e_color <= held_color;
      e_fin   <= fin_now;
    end
  end

  // pixel coordinates wrap to the output width
  assign px_base = elr_pkg::PIX_BITS'(e_cx);
  assign px_off  = elr_pkg::PIX_BITS'(e_dx);
  assign py_base = elr_pkg::PIX_BITS'(e_cy);
  assign py_off  = elr_pkg::PIX_BITS'(e_dy);

  assign pixels.valid       = e_act;
  assign pixels.pixel_x     = e_cnt[0] ? px_base + px_off : px_base - px_off;
  assign pixels.pixel_y     = e_cnt[1] ? py_base + py_off : py_base - py_off;
  assign pixels.pixel_color = e_color;
  assign pixels.last        = e_fin && (e_cnt == 2'd3);

  // status
  assign status.busy     = busy;
  assign status.updating = (state == ST_UPD);
  assign status.emitting = e_act;
  assign status.emit_cnt = e_cnt;

endmodule

### hw/rtl/ellipse_outline_rasterizer.sv
// Ellipse outline rasterizer. A start item (opcode 0) with both radii positive loads center,
// radii and color, and its error term is set in the update state of the back end; a start with
// a nonpositive radius is dropped. Each tick (opcode 1) while drawing performs one step of the
// error recurrence and emits four mirrored pixels; a tick while idle is discarded. A tick's
// four-pixel burst on the single output port holds off the next command, which can be taken
// at the earliest as the fourth pixel is accepted; the error update through the shared
// multiplier finishes inside the burst. Items are accepted into a two-entry command queue
// whenever it has room, independent of output stalls. last marks the fourth pixel of the step
// that moves y below zero. Axis pixels repeat; clipping is left to the consumer.
module ellipse_outline_rasterizer (
  input logic        clk,
  input logic        rst,
  elr_in_if.sink     cmd,
  elr_out_if.source  pixels
);

  logic                  push_valid;
  logic                  push_ready;
  elr_pkg::cmd_t         push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  elr_pkg::cmd_t         pop_data;
  elr_pkg::back_status_t status;

  // classify items and form squares
  elr_front u_front (
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decoupling queue
  elr_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // walk the outline and emit pixels
  elr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .pixels    (pixels),
    .status    (status)
  );

  // the final pixel is shown only after drawing has stopped
  assert property (@(posedge clk) disable iff (rst)
    pixels.valid && pixels.last |-> !status.busy)
    else $error("last pixel while still drawing");

  // the error update state is never entered twice in a row
  assert property (@(posedge clk) disable iff (rst)
    status.updating |=> !status.updating)
    else $error("error update stuck");

  // a burst keeps going until its fourth pixel is taken
  assert property (@(posedge clk) disable iff (rst)
    pixels.valid && pixels.ready && (status.emit_cnt != 2'd3) |=> pixels.valid)
    else $error("pixel burst cut short");

  // no command is taken while an update is in flight
  assert property (@(posedge clk) disable iff (rst)
    status.updating |-> !pop_ready)
    else $error("command popped during update");

endmodule
